FILE: rtl/jlfd_pkg.sv
package jlfd_pkg;

  localparam int unsigned EXPIRE_SECONDS = 120;
  localparam logic [7:0]  COUNTDOWN_RELOAD = 8'd5;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TALLY_W    = 8;
  localparam int unsigned LIMIT_W    = 8;
  localparam int unsigned GAP_W      = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLOOD_LIMIT = 1'b0,
    REG_QUICK_GAP   = 1'b1
  } cfg_reg_t;

  localparam logic [LIMIT_W-1:0] FLOOD_LIMIT_RST = 8'd25;
  localparam logic [GAP_W-1:0]   QUICK_GAP_RST   = 16'd60;

  // Elapsed times of 256 periods or more clear any tally, so the divider
  // only sees values below 256 * EXPIRE_SECONDS.
  localparam longint unsigned DIV_LIMIT = 64'(EXPIRE_SECONDS) * 64'd256;
  localparam int unsigned DIV_X_W = $clog2(DIV_LIMIT);
  // Reciprocal multiply: floor(x * M / 2^K) is exact for x < DIV_LIMIT.
  localparam int unsigned DIV_K   = 2 * $clog2(EXPIRE_SECONDS + 1) + 9;
  localparam int unsigned DIV_M_W = DIV_K - $clog2(EXPIRE_SECONDS) + 1;
  localparam longint unsigned DIV_M =
    ((64'd1 << DIV_K) + 64'(EXPIRE_SECONDS) - 64'd1) / 64'(EXPIRE_SECONDS);
  localparam int unsigned DIV_P_W = DIV_X_W + DIV_M_W;

endpackage

FILE: rtl/jlfd_if.sv
interface jlfd_in_if;
  import jlfd_pkg::*;
  logic              valid;
  logic              ready;
  logic              is_join;
  logic [TIME_W-1:0] current_time;

  modport source(output valid, output is_join, output current_time, input ready);
  modport sink(input valid, input is_join, input current_time, output ready);
endinterface

interface jlfd_out_if;
  import jlfd_pkg::*;
  logic               valid;
  logic               ready;
  logic               warn;
  logic               warn_on_join;
  logic [TALLY_W-1:0] event_count;

  modport source(output valid, output warn, output warn_on_join, output event_count,
                 input ready);
  modport sink(input valid, input warn, input warn_on_join, input event_count,
               output ready);
endinterface

FILE: rtl/join_leave_flood_detector.sv
// Join/leave flood detector for one client.
// items (sink): one join or leave event per transfer, with is_join and the
//   current time in seconds (wrapping, 32 bits).
// results (source): one result per event: warn, warn_on_join and the event
//   count after the update.
// cfg_we/cfg_index/cfg_data: register writes, index 0 flood_limit,
//   index 1 quick_gap_seconds; write only while no event is in flight.
// The result of an event is registered and is shown in the cycle after the
// event is taken. Throughput is one event per cycle while results is not
// stalled; the tally and countdown are updated by a single combinational
// pass (subtract, reciprocal multiply for the expire period divide,
// compare) between the input and the result register.
// A stalled result register holds its item; items is ready whenever the
// result register is empty or being taken in the same cycle.
// Reset clears the tally, countdown and time stamps, loads flood_limit = 25
// and quick_gap_seconds = 60, and empties the result register.
module join_leave_flood_detector (
  input  logic                           clk,
  input  logic                           rst,
  jlfd_in_if.sink                        items,
  jlfd_out_if.source                     results,
  input  logic                           cfg_we,
  input  logic [jlfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jlfd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import jlfd_pkg::*;

  logic [LIMIT_W-1:0] flood_limit;
  logic [GAP_W-1:0]   quick_gap_seconds;
  logic [TALLY_W-1:0] event_tally, event_tally_next;
  logic [7:0]         warn_countdown, warn_countdown_next;
  logic [TIME_W-1:0]  last_join_stamp, last_join_stamp_next;
  logic [TIME_W-1:0]  last_leave_stamp, last_leave_stamp_next;

  logic               out_valid;
  logic               out_warn;
  logic               out_warn_on_join;
  logic [TALLY_W-1:0] out_count;

  logic               accept;
  logic               flooding;
  logic [7:0]         cd_dec;
  logic               warn_now;
  logic [TIME_W-1:0]  since_leave, since_join;
  logic               expired;
  logic               quick;
  logic [TALLY_W-1:0] tally_decayed;
  logic [TALLY_W-1:0] tally_upd;

  assign items.ready = !out_valid || results.ready;
  assign accept      = items.valid && items.ready;

  jlfd_decay u_decay (
    .since_leave  (since_leave),
    .tally        (event_tally),
    .tally_decayed(tally_decayed)
  );

  always_comb begin
    flooding    = (flood_limit != '0) && (event_tally >= flood_limit);
    cd_dec      = (warn_countdown != 8'd0) ? warn_countdown - 8'd1 : warn_countdown;
    warn_now    = flooding && (cd_dec == 8'd0);
    since_leave = items.current_time - last_leave_stamp;
    since_join  = items.current_time - last_join_stamp;
    expired     = since_leave > TIME_W'(EXPIRE_SECONDS);
    quick       = (since_join < TIME_W'(quick_gap_seconds)) && (event_tally != '1);
    if (expired) begin
      tally_upd = tally_decayed;
    end else if (quick) begin
      tally_upd = event_tally + TALLY_W'(1);
    end else begin
      tally_upd = event_tally;
    end

    event_tally_next      = event_tally;
    warn_countdown_next   = warn_countdown;
    last_join_stamp_next  = last_join_stamp;
    last_leave_stamp_next = last_leave_stamp;
    if (accept) begin
      if (flooding) begin
        warn_countdown_next = warn_now ? COUNTDOWN_RELOAD : cd_dec;
      end else begin
        event_tally_next = tally_upd;
        if (items.is_join) begin
          last_join_stamp_next = items.current_time;
        end else begin
          last_leave_stamp_next = items.current_time;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flood_limit       <= FLOOD_LIMIT_RST;
      quick_gap_seconds <= QUICK_GAP_RST;
      event_tally       <= '0;
      warn_countdown    <= '0;
      last_join_stamp   <= '0;
      last_leave_stamp  <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_FLOOD_LIMIT: flood_limit       <= cfg_data[LIMIT_W-1:0];
          REG_QUICK_GAP:   quick_gap_seconds <= cfg_data[GAP_W-1:0];
          default: ;
        endcase
      end
      event_tally      <= event_tally_next;
      warn_countdown   <= warn_countdown_next;
      last_join_stamp  <= last_join_stamp_next;
      last_leave_stamp <= last_leave_stamp_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded on each input transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      out_warn         <= warn_now;
      out_warn_on_join <= warn_now && items.is_join;
      out_count        <= event_tally_next;
    end
  end

  assign results.valid        = out_valid;
  assign results.warn         = out_warn;
  assign results.warn_on_join = out_warn_on_join;
  assign results.event_count  = out_count;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!results.valid || results.ready))
    else $error("result overwritten while stalled");

  a_count_mirrors_tally: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.event_count == event_tally))
    else $error("event_count differs from tally");

  a_warn_reloads: assert property (@(posedge clk) disable iff (rst)
    (accept && warn_now) |=> (warn_countdown == COUNTDOWN_RELOAD))
    else $error("countdown not reloaded after warning");

  a_join_needs_warn: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.warn_on_join) |-> results.warn)
    else $error("warn_on_join without warn");

  a_flood_holds_stamps: assert property (@(posedge clk) disable iff (rst)
    (accept && flooding) |=> ($stable(last_join_stamp) && $stable(last_leave_stamp)))
    else $error("stamp changed on flooding event");
`endif

endmodule

FILE: rtl/jlfd_decay.sv
module jlfd_decay (
  input  logic [jlfd_pkg::TIME_W-1:0]  since_leave,
  input  logic [jlfd_pkg::TALLY_W-1:0] tally,
  output logic [jlfd_pkg::TALLY_W-1:0] tally_decayed
);
  import jlfd_pkg::*;

  logic                 beyond;
  logic [DIV_X_W-1:0]   x;
  logic [DIV_P_W-1:0]   prod;
  logic [TALLY_W-1:0]   periods;

  always_comb begin
    beyond  = 64'(since_leave) >= DIV_LIMIT;
    x       = since_leave[DIV_X_W-1:0];
    prod    = DIV_P_W'(x) * DIV_P_W'(DIV_M);
    periods = prod[DIV_K +: TALLY_W];
    if (beyond || periods >= tally) begin
      tally_decayed = '0;
    end else begin
      tally_decayed = tally - periods;
    end
  end

endmodule

FILE: tb/join_leave_flood_detector_test.sv
module join_leave_flood_detector_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jlfd_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam logic [TIME_W-1:0] PERIOD =
    (EXPIRE_SECONDS == 0) ? TIME_W'(1) : TIME_W'(EXPIRE_SECONDS);

  typedef struct packed {
    logic               warn;
    logic               warn_on_join;
    logic [TALLY_W-1:0] event_count;
  } verdict_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  jlfd_in_if  events_if ();
  jlfd_out_if verdicts_if ();

  join_leave_flood_detector i_dut (
    .clk       (clk),
    .rst       (rst),
    .items     (events_if),
    .results   (verdicts_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the detector state and its registers
  logic [LIMIT_W-1:0] flood_limit;
  logic [GAP_W-1:0]   quick_gap;
  logic [TALLY_W-1:0] tally;
  logic [7:0]         countdown;
  logic [TIME_W-1:0]  join_stamp;
  logic [TIME_W-1:0]  leave_stamp;

  verdict_t pending_verdicts[$];
  verdict_t head_verdict;
  int       mismatches = 0;
  int       quiet_cycles = 0;

  // Sender and receiver pacing
  int  burst_left = 0;
  bit  sender_gappy = 1'b1;
  int  stall_mode = 0;
  int  stall_phase = 0;
  logic [TIME_W-1:0] t_now = '0;

  function automatic verdict_t predict_verdict(logic is_join_ev, logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] since_leave;
    logic [TIME_W-1:0] since_join;
    logic [TIME_W-1:0] drop;
    verdict_t v;
    v = '0;
    if (flood_limit != 0 && tally >= flood_limit) begin
      // flooding: stamps stay frozen, only the countdown moves
      if (countdown > 0) countdown = countdown - 1'b1;
      if (countdown == 0) begin
        v.warn = 1'b1;
        countdown = COUNTDOWN_RELOAD;
      end
    end else begin
      since_leave = now - leave_stamp;
      if (since_leave > PERIOD) begin
        drop = since_leave / PERIOD;
        tally = (drop >= TIME_W'(tally)) ? '0 : tally - drop[TALLY_W-1:0];
      end else begin
        since_join = now - join_stamp;
        if (since_join < TIME_W'(quick_gap) && tally != '1) tally = tally + 1'b1;
      end
      if (is_join_ev) join_stamp = now;
      else leave_stamp = now;
    end
    v.warn_on_join = v.warn & is_join_ev;
    v.event_count  = tally;
    return v;
  endfunction

  // Called at a falling edge, returns at a falling edge with the item still driven
  task automatic send_event(input logic is_join_ev, input logic [TIME_W-1:0] stamp);
    int idle;
    if (burst_left == 0) begin
      idle = (!sender_gappy || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (idle > 0) begin
        events_if.valid <= 1'b0;
        repeat (idle) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    events_if.valid        <= 1'b1;
    events_if.is_join      <= is_join_ev;
    events_if.current_time <= stamp;
    do @(posedge clk); while (!events_if.ready);
    pending_verdicts.push_back(predict_verdict(is_join_ev, stamp));
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain_results();
    events_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_FLOOD_LIMIT: flood_limit = value[LIMIT_W-1:0];
      REG_QUICK_GAP:   quick_gap   = value[GAP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Window edges, wrap of the 32-bit time and partial decay, with reset settings
  task automatic test_time_edges();
    stall_mode = 0;
    sender_gappy = 1'b0;
    send_event(1'b1, 32'd0);
    send_event(1'b0, 32'd0);
    send_event(1'b1, 32'd30);
    send_event(1'b0, 32'd119);
    send_event(1'b1, 32'd240);
    send_event(1'b0, 32'd240);
    send_event(1'b1, 32'd360);
    send_event(1'b0, 32'hFFFF_FFFF);
    send_event(1'b0, 32'hFFFF_FFF0);
    send_event(1'b1, 32'hFFFF_FFF0);
    send_event(1'b1, 32'h0000_0010);
    send_event(1'b0, 32'h0000_0020);
    send_event(1'b1, 32'h8000_0000);
    for (int k = 0; k < 6; k++) send_event(k[0], 32'h8000_0001 + k);
    send_event(1'b1, 32'h8000_0006 + 32'd370);
    t_now = 32'h8000_0200;
    drain_results();
  endtask

  // Low limit so the tally floods quickly; countdown warns on joins and leaves
  task automatic test_flood_countdown();
    write_reg(REG_FLOOD_LIMIT, 16'd2);
    write_reg(REG_QUICK_GAP, 16'hFFFF);
    stall_mode = 2;
    sender_gappy = 1'b1;
    for (int k = 0; k < 14; k++) begin
      t_now = t_now + 1;
      send_event(~k[0], t_now);
    end
    drain_results();
  endtask

  task automatic run_phase(input int n, input logic [LIMIT_W-1:0] limit,
                           input logic [GAP_W-1:0] gap, input int step_max,
                           input bit noisy);
    int r;
    write_reg(REG_FLOOD_LIMIT, {8'($urandom), limit});
    write_reg(REG_QUICK_GAP, gap);
    stall_mode   = $urandom_range(0, 2);
    sender_gappy = ($urandom_range(0, 3) != 0);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (!noisy || r < 80) t_now = t_now + $urandom_range(0, step_max);
      else if (r < 88) t_now = t_now + $urandom_range(121, 121 * 300);
      else if (r < 95) t_now = $urandom;
      else t_now = 32'hFFFF_FFFF - $urandom_range(0, 60);
      send_event(1'($urandom_range(0, 1)), t_now);
      // hold off until the result path is empty
      if (k == n / 2) drain_results();
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    run_phase(300, 8'd0, 16'hFFFF, 2, 1'b0);    // tally saturates
    run_phase(150, 8'd255, 16'd0, 5, 1'b1);
    run_phase(150, 8'd0, 16'd0, 30, 1'b1);
    run_phase(200, 8'd1, 16'hFFFF, 10, 1'b1);
    run_phase(250, FLOOD_LIMIT_RST, QUICK_GAP_RST, 8, 1'b1);
    for (int p = 0; p < 4; p++)
      run_phase(200, ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(2, 40)),
                16'($urandom_range(0, 200)), 20, 1'b1);
  endtask

  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    case (stall_mode)
      0: verdicts_if.ready <= 1'b1;
      1: verdicts_if.ready <= ($urandom_range(0, 3) != 0);
      default: verdicts_if.ready <= (stall_phase % 9) >= 4;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && verdicts_if.valid && verdicts_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result transfer with no event pending: warn=%0b count=%0d",
               verdicts_if.warn, verdicts_if.event_count);
        mismatches++;
      end else begin
        head_verdict = pending_verdicts.pop_front();
        if (verdicts_if.warn !== head_verdict.warn) begin
          $error("warn: expected %0b, got %0b", head_verdict.warn, verdicts_if.warn);
          mismatches++;
        end
        if (verdicts_if.warn_on_join !== head_verdict.warn_on_join) begin
          $error("warn_on_join: expected %0b, got %0b",
                 head_verdict.warn_on_join, verdicts_if.warn_on_join);
          mismatches++;
        end
        if (verdicts_if.event_count !== head_verdict.event_count) begin
          $error("event_count: expected %0d, got %0d",
                 head_verdict.event_count, verdicts_if.event_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((events_if.valid && events_if.ready) || (verdicts_if.valid && verdicts_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = REG_FLOOD_LIMIT;
    cfg_data               = '0;
    events_if.valid        = 1'b0;
    events_if.is_join      = 1'b0;
    events_if.current_time = '0;
    verdicts_if.ready      = 1'b0;
    flood_limit = FLOOD_LIMIT_RST;
    quick_gap   = QUICK_GAP_RST;
    tally       = '0;
    countdown   = '0;
    join_stamp  = '0;
    leave_stamp = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_time_edges();
    test_flood_countdown();
    test_random_traffic();
    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
